>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project
// ----------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define SCFP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked assertion that also holds across reset
`define SCFP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/scfp_pkg.sv
// ----------------------------------------------------------------
// scfp_pkg
// Types and constants of the servo command frame parser
// ----------------------------------------------------------------
package scfp_pkg;

  localparam int NUM_FIELDS = 5;
  localparam int ANGLE_W    = 8;
  localparam int PULSE_W    = 12;
  localparam int CHAN_W     = 4;
  localparam int SERVO_W    = 3;
  localparam int FIELD_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(NUM_FIELDS - 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_MAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX  = 3'd5;

  // register reset values
  localparam logic [39:0] RST_MIN_ANGLES = 40'd171800666880;
  localparam logic [39:0] RST_MAX_ANGLES = 40'd582851326900;
  localparam logic [4:0]  RST_INVERT     = 5'd12;
  localparam logic [19:0] RST_CHAN_MAP   = 20'd1034304;
  localparam logic [11:0] RST_PULSE_MIN  = 12'd184;
  localparam logic [11:0] RST_PULSE_MAX  = 12'd430;

  // field parse phases
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_COMMA  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_GT    = 8'd62;

  // x / 180 is done as (x >> 2) / 45 by reciprocal multiply, exact below 2^20
  localparam int FULL_SCALE_DEG = 180;
  localparam int RECIP_DIV      = FULL_SCALE_DEG / 4;
  localparam int RECIP_SHIFT    = 24;
  localparam int RECIP_W        = 19;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((1 << RECIP_SHIFT) + RECIP_DIV - 1) / RECIP_DIV);
  localparam int QUOT_W = 13;

  typedef logic [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    logic [39:0]        min_angles;
    logic [39:0]        max_angles;
    logic [4:0]         invert;
    logic [19:0]        chan_map;
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
  } cfg_t;

  // end of frame, parser to emitter
  typedef struct packed {
    logic                        valid;
    logic                        err;
    angle_t [NUM_FIELDS-1:0]     angles;
  } frame_evt_t;

  // one result launched into the pulse pipeline
  typedef struct packed {
    logic               valid;
    logic               err;
    logic [SERVO_W-1:0] servo;
    angle_t             angle;
    logic               last;
  } launch_t;

endpackage

>>> rtl/core/scfp_regs.sv
// ----------------------------------------------------------------
// scfp_regs
// Configuration registers of the frame parser
// ----------------------------------------------------------------
module scfp_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output scfp_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_angles <= scfp_pkg::RST_MIN_ANGLES;
      cfg.max_angles <= scfp_pkg::RST_MAX_ANGLES;
      cfg.invert     <= scfp_pkg::RST_INVERT;
      cfg.chan_map   <= scfp_pkg::RST_CHAN_MAP;
      cfg.pulse_min  <= scfp_pkg::RST_PULSE_MIN;
      cfg.pulse_max  <= scfp_pkg::RST_PULSE_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scfp_pkg::REG_MIN_ANGLES: cfg.min_angles <= cfg_data;
        scfp_pkg::REG_MAX_ANGLES: cfg.max_angles <= cfg_data;
        scfp_pkg::REG_INVERT:     cfg.invert     <= cfg_data[4:0];
        scfp_pkg::REG_CHAN_MAP:   cfg.chan_map   <= cfg_data[19:0];
        scfp_pkg::REG_PULSE_MIN:  cfg.pulse_min  <= cfg_data[scfp_pkg::PULSE_W-1:0];
        scfp_pkg::REG_PULSE_MAX:  cfg.pulse_max  <= cfg_data[scfp_pkg::PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/scfp_parser.sv
// ----------------------------------------------------------------
// scfp_parser
// Byte input register and frame parse state, one byte per cycle unless a '>' waits for the emitter
// ----------------------------------------------------------------
module scfp_parser #(
  parameter int FRAME_LIMIT = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  input  logic                       emit_busy,
  output scfp_pkg::frame_evt_t       evt
);

  localparam int CNT_W = $clog2(FRAME_LIMIT + 1);

  logic                           byte_full;
  logic [7:0]                     byte_q;
  logic                           consume;

  logic                           in_frame, in_frame_next;
  logic [CNT_W-1:0]               char_count, char_count_next;
  logic [scfp_pkg::FIELD_W-1:0]   field_number, field_number_next;
  logic [1:0]                     field_chars, field_chars_next;
  scfp_pkg::angle_t               field_value, field_value_next;
  logic                           field_negative, field_negative_next;
  logic                           field_has_digit, field_has_digit_next;
  logic [1:0]                     parse_phase, parse_phase_next;
  logic                           parse_failed, parse_failed_next;

  scfp_pkg::angle_t               angle_store [scfp_pkg::NUM_FIELDS];

  logic                           is_ws, is_digit, at_last_field;
  scfp_pkg::angle_t               digit_acc;
  logic                           fin, sep;
  scfp_pkg::angle_t               fin_val;
  logic                           store_we;
  scfp_pkg::angle_t               store_val;
  logic                           evt_valid, evt_err;

  // a '>' inside a frame needs the emitter free
  assign consume  = byte_full &&
                    !(byte_q == scfp_pkg::CH_GT && in_frame && emit_busy);
  assign in_ready = !byte_full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_full <= 1'b0;
    end else if (in_ready) begin
      byte_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= rx_byte;
    end
  end

  assign is_ws = (byte_q == scfp_pkg::CH_SPACE) ||
                 (byte_q >= scfp_pkg::CH_TAB && byte_q <= scfp_pkg::CH_CR);
  assign is_digit = (byte_q >= scfp_pkg::CH_ZERO) && (byte_q <= scfp_pkg::CH_NINE);
  assign at_last_field = (field_number >= scfp_pkg::LAST_FIELD);
  // value * 10 + digit, modulo 256
  assign digit_acc = {field_value[4:0], 3'b000} + {field_value[6:0], 1'b0} +
                     {4'b0000, byte_q[3:0]};

  always_comb begin
    in_frame_next        = in_frame;
    char_count_next      = char_count;
    field_number_next    = field_number;
    field_chars_next     = field_chars;
    field_value_next     = field_value;
    field_negative_next  = field_negative;
    field_has_digit_next = field_has_digit;
    parse_phase_next     = parse_phase;
    parse_failed_next    = parse_failed;
    fin                  = 1'b0;
    sep                  = 1'b0;
    fin_val              = field_value;
    store_we             = 1'b0;
    store_val            = field_value;
    evt_valid            = 1'b0;
    evt_err              = 1'b0;
    if (consume) begin
      if (byte_q == scfp_pkg::CH_LT) begin
        in_frame_next        = 1'b1;
        char_count_next      = CNT_W'(1);
        field_number_next    = '0;
        field_chars_next     = '0;
        field_value_next     = '0;
        field_negative_next  = 1'b0;
        field_has_digit_next = 1'b0;
        parse_phase_next     = scfp_pkg::PH_START;
        parse_failed_next    = 1'b0;
      end else if (in_frame) begin
        char_count_next = char_count + 1'b1;
        if (!parse_failed && parse_phase != scfp_pkg::PH_DONE) begin
          if (byte_q == scfp_pkg::CH_NUL) begin
            // end of text: only a last field with digits may complete
            if (parse_phase == scfp_pkg::PH_DIGITS && field_has_digit && at_last_field) begin
              fin = 1'b1;
            end else begin
              parse_failed_next = 1'b1;
            end
          end else begin
            case (parse_phase)
              scfp_pkg::PH_START: begin
                if (!is_ws) begin
                  field_value_next    = '0;
                  field_chars_next    = 2'd1;
                  field_negative_next = (byte_q == scfp_pkg::CH_MINUS);
                  if (byte_q == scfp_pkg::CH_PLUS || byte_q == scfp_pkg::CH_MINUS) begin
                    field_has_digit_next = 1'b0;
                    parse_phase_next     = scfp_pkg::PH_DIGITS;
                  end else if (is_digit) begin
                    field_has_digit_next = 1'b1;
                    field_value_next     = {4'b0000, byte_q[3:0]};
                    parse_phase_next     = scfp_pkg::PH_DIGITS;
                  end else begin
                    parse_failed_next = 1'b1;
                  end
                end
              end
              scfp_pkg::PH_DIGITS: begin
                if (is_digit) begin
                  field_value_next     = digit_acc;
                  field_has_digit_next = 1'b1;
                  field_chars_next     = field_chars + 1'b1;
                  // three characters taken, field is full
                  if (field_chars == 2'd2) begin
                    fin     = 1'b1;
                    fin_val = digit_acc;
                  end
                end else if (!field_has_digit) begin
                  parse_failed_next = 1'b1;
                end else begin
                  fin = 1'b1;
                  sep = !at_last_field;
                end
              end
              scfp_pkg::PH_COMMA: begin
                sep = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        if (fin) begin
          store_we         = 1'b1;
          store_val        = field_negative ? scfp_pkg::ANGLE_W'(~fin_val + 8'd1) : fin_val;
          parse_phase_next = at_last_field ? scfp_pkg::PH_DONE : scfp_pkg::PH_COMMA;
        end
        if (sep) begin
          if (byte_q == scfp_pkg::CH_COMMA) begin
            field_number_next = field_number + 1'b1;
            parse_phase_next  = scfp_pkg::PH_START;
          end else begin
            parse_failed_next = 1'b1;
          end
        end
        if (byte_q == scfp_pkg::CH_GT) begin
          in_frame_next = 1'b0;
          evt_valid     = 1'b1;
          evt_err       = !(parse_phase_next == scfp_pkg::PH_DONE && !parse_failed_next);
        end else if (char_count_next >= CNT_W'(FRAME_LIMIT)) begin
          // overlong frame dropped without a result
          in_frame_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      char_count      <= '0;
      field_number    <= '0;
      field_chars     <= '0;
      field_value     <= '0;
      field_negative  <= 1'b0;
      field_has_digit <= 1'b0;
      parse_phase     <= scfp_pkg::PH_START;
      parse_failed    <= 1'b0;
    end else begin
      in_frame        <= in_frame_next;
      char_count      <= char_count_next;
      field_number    <= field_number_next;
      field_chars     <= field_chars_next;
      field_value     <= field_value_next;
      field_negative  <= field_negative_next;
      field_has_digit <= field_has_digit_next;
      parse_phase     <= parse_phase_next;
      parse_failed    <= parse_failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      angle_store[field_number] <= store_val;
    end
  end

  // angles as they stand after this byte, last field included
  always_comb begin
    evt.valid = evt_valid;
    evt.err   = evt_err;
    for (int k = 0; k < scfp_pkg::NUM_FIELDS; k++) begin
      evt.angles[k] = (store_we && field_number == scfp_pkg::FIELD_W'(k)) ?
                      store_val : angle_store[k];
    end
  end

endmodule

>>> rtl/core/scfp_emitter.sv
// ----------------------------------------------------------------
// scfp_emitter
// Sends the results of one frame into the pulse pipeline, one a cycle while it advances
// ----------------------------------------------------------------
module scfp_emitter #(
  parameter int NUM_CHANNELS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scfp_pkg::frame_evt_t  evt,
  input  logic                  adv,
  output logic                  busy,
  output scfp_pkg::launch_t     launch
);

  localparam logic [scfp_pkg::SERVO_W-1:0] LAST_SERVO =
    scfp_pkg::SERVO_W'(NUM_CHANNELS - 1);

  logic [scfp_pkg::SERVO_W-1:0] servo;
  logic                         is_err;
  scfp_pkg::angle_t             snap [NUM_CHANNELS];

  assign launch.valid = busy;
  assign launch.err   = is_err;
  assign launch.servo = servo;
  assign launch.angle = snap[0];
  assign launch.last  = is_err || (servo == LAST_SERVO);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      servo  <= '0;
      is_err <= 1'b0;
    end else if (evt.valid) begin
      busy   <= 1'b1;
      servo  <= '0;
      is_err <= evt.err;
    end else if (busy && adv) begin
      if (launch.last) begin
        busy <= 1'b0;
      end else begin
        servo <= servo + 1'b1;
      end
    end
  end

  // angle snapshot shifts down so the current servo sits in entry zero
  always_ff @(posedge clk) begin
    if (evt.valid) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        snap[k] <= evt.angles[k];
      end
    end else if (busy && adv) begin
      for (int k = 0; k < NUM_CHANNELS - 1; k++) begin
        snap[k] <= snap[k+1];
      end
    end
  end

endmodule

>>> rtl/core/scfp_pulse_pipe.sv
// ----------------------------------------------------------------
// scfp_pulse_pipe
// Clamp, mirror and angle to pulse mapping, four stages to the output
// ----------------------------------------------------------------
module scfp_pulse_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  scfp_pkg::cfg_t                    cfg,
  input  scfp_pkg::launch_t                 launch,
  output logic                              adv,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [scfp_pkg::CHAN_W-1:0]       channel,
  output logic [scfp_pkg::PULSE_W-1:0]      pulse_width,
  output logic                              last
);

  // stage a: clamped and mirrored angle
  logic                            a_valid, a_err, a_last;
  logic [scfp_pkg::CHAN_W-1:0]     a_chan;
  scfp_pkg::angle_t                a_deg;
  // stage b: signed product
  logic                            b_valid, b_err, b_last;
  logic [scfp_pkg::CHAN_W-1:0]     b_chan;
  logic signed [21:0]              b_prod;
  // stage c: quotient magnitude
  logic                            c_valid, c_err, c_last, c_neg;
  logic [scfp_pkg::CHAN_W-1:0]     c_chan;
  logic [scfp_pkg::QUOT_W-1:0]     c_quot;

  scfp_pkg::angle_t                lo, hi, clamped, mirrored;
  logic signed [12:0]              span;
  logic signed [21:0]              prod_c;
  logic [19:0]                     mag_c;
  logic [36:0]                     recip_c;
  logic signed [14:0]              quot_s, sum_c;
  logic [scfp_pkg::PULSE_W-1:0]    sat_c;

  assign adv = !out_valid || out_ready;

  assign lo = cfg.min_angles[{launch.servo, 3'b000} +: scfp_pkg::ANGLE_W];
  assign hi = cfg.max_angles[{launch.servo, 3'b000} +: scfp_pkg::ANGLE_W];

  always_comb begin
    if (launch.angle < lo) begin
      clamped = lo;
    end else if (launch.angle > hi) begin
      clamped = hi;
    end else begin
      clamped = launch.angle;
    end
    mirrored = lo + hi - clamped;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_err  <= launch.err;
      a_last <= launch.last;
      a_chan <= launch.err ? '0 : cfg.chan_map[{launch.servo, 2'b00} +: scfp_pkg::CHAN_W];
      a_deg  <= cfg.invert[launch.servo] ? mirrored : clamped;
    end
  end

  assign span   = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
  assign prod_c = $signed({1'b0, a_deg}) * span;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_err  <= a_err;
      b_last <= a_last;
      b_chan <= a_chan;
      b_prod <= prod_c;
    end
  end

  // truncation toward zero: divide the magnitude, sign goes back later
  assign mag_c   = b_prod[21] ? 20'(-b_prod) : b_prod[19:0];
  assign recip_c = mag_c[19:2] * scfp_pkg::RECIP_MULT;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_err  <= b_err;
      c_last <= b_last;
      c_chan <= b_chan;
      c_neg  <= b_prod[21];
      c_quot <= recip_c[scfp_pkg::RECIP_SHIFT +: scfp_pkg::QUOT_W];
    end
  end

  assign quot_s = $signed({2'b00, c_quot});
  assign sum_c  = $signed({3'b000, cfg.pulse_min}) + (c_neg ? -quot_s : quot_s);

  always_comb begin
    if (sum_c < 15'sd0) begin
      sat_c = '0;
    end else if (sum_c > 15'sd4095) begin
      sat_c = '1;
    end else begin
      sat_c = sum_c[scfp_pkg::PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= launch.valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status      <= c_err;
      channel     <= c_chan;
      pulse_width <= c_err ? '0 : sat_c;
      last        <= c_last;
    end
  end

endmodule

>>> rtl/core/servo_command_frame_parser_unit.sv
// ----------------------------------------------------------------
// servo_command_frame_parser_unit
// Parses <a,b,c,d,e> command frames and gives one pulse width per
// servo, or one error result for a bad frame
// ----------------------------------------------------------------
//  channel  signals                                       direction
//  in       in_valid in_ready rx_byte                     byte in
//  out      out_valid out_ready status channel             result out
//           pulse_width last
//  cfg      cfg_valid cfg_ready cfg_index cfg_data        register write
//
// one byte is taken per cycle unless a '>' waits in the input register
// until the emitter is free; a good frame gives NUM_CHANNELS results on
// consecutive cycles from the emitter while the pipeline advances; the
// output register stalls the whole pulse pipeline, up to four results
// sit in flight; reset is synchronous, clears parse state and restores
// the register defaults, angle storage needs no clearing
// ----------------------------------------------------------------
module servo_command_frame_parser_unit #(
  parameter int NUM_CHANNELS = 5,
  parameter int FRAME_LIMIT  = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             status,
  output logic [scfp_pkg::CHAN_W-1:0]      channel,
  output logic [scfp_pkg::PULSE_W-1:0]     pulse_width,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  scfp_pkg::cfg_t        cfg;
  scfp_pkg::frame_evt_t  evt;
  scfp_pkg::launch_t     launch;
  logic                  emit_busy;
  logic                  adv;

  assign cfg_ready = 1'b1;

  scfp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scfp_parser #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .emit_busy (emit_busy),
    .evt       (evt)
  );

  scfp_emitter #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_emitter (
    .clk    (clk),
    .rst    (rst),
    .evt    (evt),
    .adv    (adv),
    .busy   (emit_busy),
    .launch (launch)
  );

  scfp_pulse_pipe u_pulse (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .launch      (launch),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .channel     (channel),
    .pulse_width (pulse_width),
    .last        (last)
  );

endmodule

>>> rtl/core/scfp_checker.sv
// ----------------------------------------------------------------
// scfp_checker
// Port level checks of the frame parser result stream
// ----------------------------------------------------------------
`include "assert_macros.svh"

module scfp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             status,
  input logic [scfp_pkg::CHAN_W-1:0]      channel,
  input logic [scfp_pkg::PULSE_W-1:0]     pulse_width,
  input logic                             last
);

  `SCFP_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result shown right after reset")

  `SCFP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(channel) && $stable(pulse_width) && $stable(last), "stalled result changed")

  // an error result stands alone with zero payload
  `SCFP_ASSERT(a_err_form, clk, rst, out_valid && status |-> last && channel == 4'd0 && pulse_width == 12'd0, "malformed error result")

  // a run of pulses is never broken by an error result
  `SCFP_ASSERT(a_run_whole, clk, rst, $past(!rst && out_valid && out_ready && !last) && out_valid |-> !status, "pulse run cut short")

endmodule

bind servo_command_frame_parser_unit scfp_checker u_scfp_checker (.*);

>>> tb/tb_servo_command_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// tb_servo_command_frame_parser_unit
// Streams command frames into the parser, good and broken, under
// several register settings, and checks every pulse and error result
// against a byte-level parser model kept in the scoreboard
// ----------------------------------------------------------------
module tb_servo_command_frame_parser_unit;

  localparam int SERVOS      = 5;
  localparam int FRAME_LIMIT = 40;
  localparam int SETTLE      = 12;
  localparam int WATCHDOG    = 4000;
  localparam int N_SETTINGS  = 7;
  localparam int PHASE_BYTES = 44;

  typedef struct packed {
    logic                         status;
    logic [scfp_pkg::CHAN_W-1:0]  channel;
    logic [scfp_pkg::PULSE_W-1:0] pulse;
    logic                         last;
  } pulse_res_t;

  typedef enum int {
    FLAW_NONE, FLAW_BYTE, FLAW_NO_END, FLAW_BARE_SIGN, FLAW_LONG, FLAW_NUL, FLAW_WIDE
  } flaw_t;

  class pulse_scoreboard;
    logic [39:0]                  min_angles, max_angles;
    logic [4:0]                   invert;
    logic [19:0]                  chan_map;
    logic [scfp_pkg::PULSE_W-1:0] pulse_min, pulse_max;

    bit                 in_frame, negative, has_digit, failed;
    logic [5:0]         char_count;
    logic [2:0]         field_no;
    logic [1:0]         nchars, phase;
    logic [7:0]         value;
    logic [7:0]         angles [scfp_pkg::NUM_FIELDS];

    pulse_res_t         pending_pulses [$];
    int                 mismatches, pulses_seen, errors_seen;

    function new();
      min_angles = scfp_pkg::RST_MIN_ANGLES;
      max_angles = scfp_pkg::RST_MAX_ANGLES;
      invert     = scfp_pkg::RST_INVERT;
      chan_map   = scfp_pkg::RST_CHAN_MAP;
      pulse_min  = scfp_pkg::RST_PULSE_MIN;
      pulse_max  = scfp_pkg::RST_PULSE_MAX;
      start_frame();
      in_frame   = 0;
      char_count = '0;
      foreach (angles[i]) angles[i] = '0;
      mismatches  = 0;
      pulses_seen = 0;
      errors_seen = 0;
    endfunction

    function void set_reg(logic [scfp_pkg::CFG_IDX_W-1:0] idx,
                          logic [scfp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        scfp_pkg::REG_MIN_ANGLES: min_angles = data;
        scfp_pkg::REG_MAX_ANGLES: max_angles = data;
        scfp_pkg::REG_INVERT:     invert     = data[4:0];
        scfp_pkg::REG_CHAN_MAP:   chan_map   = data[19:0];
        scfp_pkg::REG_PULSE_MIN:  pulse_min  = data[scfp_pkg::PULSE_W-1:0];
        scfp_pkg::REG_PULSE_MAX:  pulse_max  = data[scfp_pkg::PULSE_W-1:0];
        default: ;
      endcase
    endfunction

    function void start_frame();
      in_frame   = 1;
      char_count = 6'd1;
      field_no   = '0;
      nchars     = '0;
      value      = '0;
      negative   = 0;
      has_digit  = 0;
      phase      = scfp_pkg::PH_START;
      failed     = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == scfp_pkg::CH_SPACE || (c >= scfp_pkg::CH_TAB && c <= scfp_pkg::CH_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= scfp_pkg::CH_ZERO && c <= scfp_pkg::CH_NINE;
    endfunction

    function void store_field();
      logic [7:0] v;
      v = value;
      if (negative) v = -v;
      if (field_no < scfp_pkg::NUM_FIELDS) angles[field_no] = v;
      phase = (field_no >= scfp_pkg::LAST_FIELD) ? scfp_pkg::PH_DONE : scfp_pkg::PH_COMMA;
    endfunction

    function void next_field(logic [7:0] c);
      if (c == scfp_pkg::CH_COMMA) begin
        field_no = field_no + 3'd1;
        phase    = scfp_pkg::PH_START;
      end else begin
        failed = 1;
      end
    endfunction

    function void feed(logic [7:0] c);
      if (failed || phase == scfp_pkg::PH_DONE) return;
      // a zero byte only rescues a fifth field that already has digits
      if (c == scfp_pkg::CH_NUL) begin
        if (phase == scfp_pkg::PH_DIGITS && has_digit && field_no >= scfp_pkg::LAST_FIELD)
          store_field();
        else failed = 1;
        return;
      end
      case (phase)
        scfp_pkg::PH_START: begin
          if (is_blank(c)) return;
          value    = '0;
          nchars   = 2'd1;
          negative = (c == scfp_pkg::CH_MINUS);
          if (c == scfp_pkg::CH_PLUS || c == scfp_pkg::CH_MINUS) begin
            has_digit = 0;
          end else if (is_digit(c)) begin
            has_digit = 1;
            value     = c - scfp_pkg::CH_ZERO;
          end else begin
            failed = 1;
            return;
          end
          phase = scfp_pkg::PH_DIGITS;
        end
        scfp_pkg::PH_DIGITS: begin
          if (is_digit(c)) begin
            value     = value * 8'd10 + (c - scfp_pkg::CH_ZERO);
            has_digit = 1;
            nchars    = nchars + 2'd1;
            if (nchars >= 2'd3) store_field();
          end else if (!has_digit) begin
            failed = 1;
          end else begin
            store_field();
            if (phase == scfp_pkg::PH_COMMA) next_field(c);
          end
        end
        default: next_field(c);
      endcase
    endfunction

    function logic [scfp_pkg::PULSE_W-1:0] servo_pulse(int i);
      int lo, hi, d, prod, r;
      lo = min_angles[8*i +: 8];
      hi = max_angles[8*i +: 8];
      d  = angles[i];
      if (d < lo) d = lo;
      else if (d > hi) d = hi;
      if (invert[i]) d = (lo + hi - d) & 255;
      prod = d * (int'(pulse_max) - int'(pulse_min));
      r    = prod / 180 + int'(pulse_min);
      if (r < 0) r = 0;
      if (r > 4095) r = 4095;
      return scfp_pkg::PULSE_W'(r);
    endfunction

    // returns 1 when the byte was taken by a frame rather than dropped
    function bit take_byte(logic [7:0] b);
      pulse_res_t res;
      if (b == scfp_pkg::CH_LT) begin
        start_frame();
        return 1;
      end
      if (!in_frame) return 0;
      char_count = char_count + 6'd1;
      feed(b);
      if (b == scfp_pkg::CH_GT) begin
        in_frame = 0;
        if (phase == scfp_pkg::PH_DONE && !failed) begin
          for (int i = 0; i < SERVOS; i++) begin
            res.status  = 1'b0;
            res.channel = chan_map[4*i +: 4];
            res.pulse   = servo_pulse(i);
            res.last    = (i == SERVOS - 1);
            pending_pulses.push_back(res);
          end
        end else begin
          res = '{status: 1'b1, channel: '0, pulse: '0, last: 1'b1};
          pending_pulses.push_back(res);
        end
        return 1;
      end
      // overlong frame is dropped without a result
      if (char_count >= FRAME_LIMIT) in_frame = 0;
      return 1;
    endfunction

    function void report(bit had_want, pulse_res_t want, pulse_res_t got);
      mismatches++;
      if (mismatches <= 10) begin
        if (had_want)
          $display({"result mismatch: expected status %0d channel %0d pulse %0d last %0d,",
                    " got %0d %0d %0d %0d"},
                   want.status, want.channel, want.pulse, want.last,
                   got.status, got.channel, got.pulse, got.last);
        else
          $display("unexpected result: status %0d channel %0d pulse %0d last %0d",
                   got.status, got.channel, got.pulse, got.last);
      end
    endfunction

    function void check_pulse(pulse_res_t got);
      pulse_res_t want;
      if (pending_pulses.size() == 0) begin
        report(1'b0, '0, got);
        return;
      end
      want = pending_pulses.pop_front();
      if (want.status) errors_seen++;
      else pulses_seen++;
      if (got.status !== want.status || got.channel !== want.channel ||
          got.pulse !== want.pulse || got.last !== want.last)
        report(1'b1, want, got);
    endfunction
  endclass

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  logic [7:0]                      rx_byte   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            status;
  logic [scfp_pkg::CHAN_W-1:0]     channel;
  logic [scfp_pkg::PULSE_W-1:0]    pulse_width;
  logic                            last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [scfp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  pulse_scoreboard sb = new();
  logic [7:0]      frame_bytes [$];
  int              used_bytes = 0;
  int              quiet      = 0;
  bit              calm       = 0;

  servo_command_frame_parser_unit #(
    .NUM_CHANNELS(SERVOS),
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .channel    (channel),
    .pulse_width(pulse_width),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check, random backpressure, stall watchdog count
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      quiet     <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_pulse(pulse_res_t'{status, channel, pulse_width, last});
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      out_ready <= calm || ($urandom_range(0, 99) >= 38);
    end
  end

  initial begin
    do @(posedge clk); while (quiet < WATCHDOG);
    $display("watchdog: no request accepted for %0d cycles", WATCHDOG);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 38);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    if (sb.take_byte(b)) used_bytes++;
  endtask

  task automatic send_queued();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic write_reg(input logic [scfp_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [scfp_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  // hold off input until every result is back and the pipeline is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] blank_char();
    int c;
    c = $urandom_range(scfp_pkg::CH_TAB, scfp_pkg::CH_CR + 1);
    return (c > scfp_pkg::CH_CR) ? scfp_pkg::CH_SPACE : 8'(c);
  endfunction

  task automatic add_field(input bit bare, input bit wide);
    string digits;
    int    sign_pick, v, maxd;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) frame_bytes.push_back(blank_char());
    sign_pick = wide ? 9 : bare ? $urandom_range(0, 1) : $urandom_range(0, 9);
    if (sign_pick == 0) frame_bytes.push_back(scfp_pkg::CH_MINUS);
    else if (sign_pick == 1) frame_bytes.push_back(scfp_pkg::CH_PLUS);
    // the sign uses one of the three characters
    maxd = (sign_pick <= 1) ? 2 : 3;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = (maxd == 3) ? 180 : 99;
      2:       v = (maxd == 3) ? 255 : 1;
      default: v = $urandom_range(0, (maxd == 3) ? 999 : 99);
    endcase
    digits = $sformatf("%0d", v);
    if (digits.len() < maxd && $urandom_range(0, 3) == 0) digits = {"0", digits};
    if (wide) digits = $sformatf("%04d", $urandom_range(0, 9999));
    if (bare) digits = "";
    push_text(digits);
  endtask

  task automatic build_frame(input flaw_t flaw);
    int         spot, n;
    logic [7:0] b;
    spot = $urandom_range(0, scfp_pkg::NUM_FIELDS - 1);
    frame_bytes.push_back(scfp_pkg::CH_LT);
    for (int i = 0; i < scfp_pkg::NUM_FIELDS; i++) begin
      if (i > 0) frame_bytes.push_back(scfp_pkg::CH_COMMA);
      if (flaw == FLAW_LONG && i == spot)
        repeat (FRAME_LIMIT) frame_bytes.push_back(scfp_pkg::CH_SPACE);
      add_field(flaw == FLAW_BARE_SIGN && i == spot, flaw == FLAW_WIDE && i == spot);
      if (flaw == FLAW_NUL && i == spot) frame_bytes.push_back(scfp_pkg::CH_NUL);
    end
    if (flaw != FLAW_NO_END) begin
      case ($urandom_range(0, 7))
        6: begin
          // trailing text, never a frame start
          n = $urandom_range(1, 4);
          repeat (n) begin
            b = 8'($urandom_range(32, 125));
            if (b >= scfp_pkg::CH_LT) b = b + 8'd1;
            frame_bytes.push_back(b);
          end
        end
        7:       frame_bytes.push_back(scfp_pkg::CH_NUL);
        default: ;
      endcase
      frame_bytes.push_back(scfp_pkg::CH_GT);
    end
    if (flaw == FLAW_BYTE)
      frame_bytes[$urandom_range(1, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  task automatic queue_random_chunk();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      build_frame(FLAW_NONE);
    else if (pick < 90)
      build_frame(flaw_t'($urandom_range(FLAW_BYTE, FLAW_WIDE)));
    else
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic apply_setting(input int k);
    logic [39:0]                  lo_a, hi_a;
    logic [4:0]                   inv;
    logic [19:0]                  cmap;
    logic [scfp_pkg::PULSE_W-1:0] pmin, pmax, swap;
    lo_a = 40'({$urandom, $urandom});
    hi_a = 40'({$urandom, $urandom});
    inv  = 5'($urandom);
    cmap = 20'($urandom);
    pmin = scfp_pkg::PULSE_W'($urandom);
    pmax = scfp_pkg::PULSE_W'($urandom);
    case (k)
      1: begin
        lo_a = '0;
        hi_a = {5{8'd180}};
        inv  = '0;
        cmap = 20'h43210;
        pmin = '0;
        pmax = '1;
      end
      2: begin
        // lower limits above upper ones, falling pulse slope
        for (int i = 0; i < scfp_pkg::NUM_FIELDS; i++) begin
          lo_a[8*i +: 8] = 8'($urandom_range(100, 255));
          hi_a[8*i +: 8] = 8'($urandom_range(0, 99));
        end
        inv  = '1;
        cmap = '1;
        pmin = '1;
        pmax = '0;
      end
      3: begin
        if (pmin > pmax) begin
          swap = pmin;
          pmin = pmax;
          pmax = swap;
        end
      end
      4: begin
        lo_a = '1;
        hi_a = '1;
        pmax = pmin;
      end
      5: begin
        lo_a = '0;
        hi_a = '0;
        inv  = '0;
        cmap = '0;
        pmin = '0;
        pmax = '0;
      end
      6: begin
        lo_a = '1;
        hi_a = '1;
        inv  = '1;
        cmap = '1;
        pmin = '1;
        pmax = '1;
      end
      default: ;
    endcase
    wait_idle();
    write_reg(scfp_pkg::REG_MIN_ANGLES, scfp_pkg::CFG_DATA_W'(lo_a));
    write_reg(scfp_pkg::REG_MAX_ANGLES, scfp_pkg::CFG_DATA_W'(hi_a));
    write_reg(scfp_pkg::REG_INVERT,     scfp_pkg::CFG_DATA_W'(inv));
    write_reg(scfp_pkg::REG_CHAN_MAP,   scfp_pkg::CFG_DATA_W'(cmap));
    write_reg(scfp_pkg::REG_PULSE_MIN,  scfp_pkg::CFG_DATA_W'(pmin));
    write_reg(scfp_pkg::REG_PULSE_MAX,  scfp_pkg::CFG_DATA_W'(pmax));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // noise before any frame, signed and padded fields, zero byte end, bare sign
    frame_bytes.push_back(8'hFF);
    push_text("<-1,+2,3,\t255,99");
    frame_bytes.push_back(scfp_pkg::CH_NUL);
    frame_bytes.push_back(scfp_pkg::CH_GT);
    push_text("<+,>");
    send_queued();

    for (int k = 0; k < N_SETTINGS; k++) begin
      if (k > 0) apply_setting(k);
      calm   <= (k == 3);
      target = used_bytes + PHASE_BYTES;
      while (used_bytes < target) begin
        queue_random_chunk();
        send_queued();
      end
    end

    wait_idle();
    $display("sent %0d frame bytes under %0d register settings",
             used_bytes, N_SETTINGS);
    $display("results seen: %0d pulse and %0d error",
             sb.pulses_seen, sb.errors_seen);
    if (sb.mismatches == 0 && sb.pending_pulses.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/scfp_pkg.sv
rtl/core/scfp_regs.sv
rtl/core/scfp_parser.sv
rtl/core/scfp_emitter.sv
rtl/core/scfp_pulse_pipe.sv
rtl/core/servo_command_frame_parser_unit.sv
rtl/core/scfp_checker.sv
tb/tb_servo_command_frame_parser_unit.sv
